[rtl/robin_hood_hash_table_top_defines.svh]
// ----------------------------------------------------------------------------
// Robin Hood hash table assertion macros
// Concurrent assertion wrappers, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef ROBIN_HOOD_HASH_TABLE_TOP_DEFINES_SVH
`define ROBIN_HOOD_HASH_TABLE_TOP_DEFINES_SVH

`ifndef SYNTH
`define RHH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RHH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RHH_ASSERT(lbl, prop, msg)
`define RHH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/rhh_pkg.sv]
// ----------------------------------------------------------------------------
// Robin Hood hash table package
// Sizes, status and mode codes, slot and transaction payload types.
// ----------------------------------------------------------------------------
package rhh_pkg;

  localparam int SLOTS      = 1024;
  localparam int ADDR_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int LOAD_NUM   = 870;
  localparam int LOAD_SHIFT = 10;
  localparam int PROD_W     = CNT_W + $clog2(LOAD_NUM + 1);

  localparam logic [15:0] NO_VALUE = 16'hFFFF;
  localparam logic [31:0] EMPTY_KEY = 32'd0;

  // reset capacity and its load limit
  localparam logic [CNT_W-1:0] CAP_RESET   = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'((SLOTS * LOAD_NUM) >> LOAD_SHIFT);

  // operation modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_BAD    = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;

  typedef struct packed {
    logic [31:0]       key;
    logic [15:0]       value;
    logic [ADDR_W-1:0] probe_len;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] hkey;
    logic [15:0] value;
  } req_t;

  typedef struct packed {
    logic [15:0]      value_res;
    logic [2:0]       status;
    logic [CNT_W-1:0] entry_count;
  } rsp_t;

endpackage

[rtl/rhh_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rhh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/robin_hood_hash_table_top.sv]
// ----------------------------------------------------------------------------
// Robin Hood hash table
// Open-addressed table of 32-bit key hashes with 16-bit values, insert,
// lookup and remove with backward-shift deletion.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. An invalid key or mode is accepted
// and goes straight to the result. Any other transaction is accepted, forms
// the home slot with a bit-serial remainder of the 32-bit key by capacity,
// then searches by reading each probed slot through the single slot RAM
// read port and evaluating it in a separate state. An accepted insert then
// walks again from the home slot to the first empty slot, reading each slot
// and then evaluating and writing it, and a remove reads and rewrites each
// slot after the found one until the backward shift stops. The done state
// hands the result to the output register, waiting while an earlier result
// is still not taken. After reset and after every capacity write the store
// is cleared one slot a cycle over all 1024 slots, during which req_ready is low.
`include "robin_hood_hash_table_top_defines.svh"

module robin_hood_hash_table_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  rhh_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output rhh_pkg::rsp_t             rsp,
  input  logic                      cfg_we,
  input  logic [rhh_pkg::CNT_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_FIND_RD, S_FIND_EV, S_INS_RD, S_INS_EV,
    S_REM_RD, S_REM_EV, S_REM_FIN, S_DONE
  } state_t;

  state_t state;

  logic [rhh_pkg::CNT_W-1:0]  capacity;
  logic [rhh_pkg::CNT_W-1:0]  load_limit;
  logic [rhh_pkg::CNT_W-1:0]  count;
  logic [rhh_pkg::ADDR_W-1:0] clr_idx;
  logic [1:0]                 mode;
  logic [31:0]                cur_key;
  logic [15:0]                cur_val;
  logic [rhh_pkg::ADDR_W-1:0] cur_dist;
  logic [31:0]                dq;
  logic [4:0]                 div_cnt;
  logic [rhh_pkg::ADDR_W-1:0] idx;
  logic [rhh_pkg::ADDR_W-1:0] home;
  logic [rhh_pkg::CNT_W-1:0]  nprobe;
  logic [15:0]                res_value;
  logic [2:0]                 res_status;

  logic                       ram_we;
  logic [rhh_pkg::ADDR_W-1:0] ram_waddr;
  rhh_pkg::slot_t             ram_wdata;
  logic [rhh_pkg::ADDR_W-1:0] ram_raddr;
  rhh_pkg::slot_t             rd;

  logic [rhh_pkg::ADDR_W-1:0] idx_nx;
  logic [rhh_pkg::CNT_W-1:0]  trial;
  logic [rhh_pkg::ADDR_W-1:0] rem_step;
  logic [rhh_pkg::CNT_W-1:0]  nprobe_inc;
  logic                       find_miss;
  logic [rhh_pkg::CNT_W-1:0]  cap_in;
  logic [rhh_pkg::PROD_W-1:0] cap_prod;
  logic                       rsp_load;

  assign req_ready = (state == S_IDLE);

  // result register can take a new transaction
  assign rsp_load = (state == S_DONE) && (!rsp_valid || rsp_ready);

  // linear probe step with wrap at capacity
  assign idx_nx = ((rhh_pkg::CNT_W'(idx) + 1'b1) >= capacity) ? '0 : idx + 1'b1;

  // one restoring remainder step per cycle
  assign trial    = {idx, dq[31]};
  assign rem_step = (trial >= capacity) ? rhh_pkg::ADDR_W'(trial - capacity)
                                        : trial[rhh_pkg::ADDR_W-1:0];

  assign nprobe_inc = nprobe + 1'b1;
  assign find_miss  = (rd.key == rhh_pkg::EMPTY_KEY) ||
                      (nprobe > rhh_pkg::CNT_W'(rd.probe_len)) ||
                      (nprobe_inc >= capacity);

  // capacity clamp and load limit for a config write
  always_comb begin
    if (cfg_wdata < rhh_pkg::CNT_W'(2)) begin
      cap_in = rhh_pkg::CNT_W'(2);
    end else if (cfg_wdata > rhh_pkg::CAP_RESET) begin
      cap_in = rhh_pkg::CAP_RESET;
    end else begin
      cap_in = cfg_wdata;
    end
    cap_prod = rhh_pkg::PROD_W'(cap_in) * rhh_pkg::PROD_W'(rhh_pkg::LOAD_NUM);
  end

  // slot RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    ram_raddr = idx;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
      end
      S_INS_EV: begin
        if ((rd.key == rhh_pkg::EMPTY_KEY) || (cur_dist > rd.probe_len)) begin
          ram_we    = 1'b1;
          ram_wdata = '{key: cur_key, value: cur_val, probe_len: cur_dist};
        end
      end
      S_REM_RD: begin
        ram_raddr = idx_nx;
      end
      S_REM_EV: begin
        ram_we = 1'b1;
        if ((rd.key != rhh_pkg::EMPTY_KEY) && (rd.probe_len != '0)) begin
          ram_wdata = '{key: rd.key, value: rd.value, probe_len: rd.probe_len - 1'b1};
        end
      end
      S_REM_FIN: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  rhh_ram #(
    .WIDTH (rhh_pkg::SLOT_W),
    .DEPTH (rhh_pkg::SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  // sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      capacity   <= rhh_pkg::CAP_RESET;
      load_limit <= rhh_pkg::LIMIT_RESET;
      count      <= '0;
      rsp_valid  <= 1'b0;
    end else if (cfg_we) begin
      // capacity write restarts the clearing sweep
      capacity   <= cap_in;
      load_limit <= rhh_pkg::CNT_W'(cap_prod >> rhh_pkg::LOAD_SHIFT);
      count      <= '0;
      clr_idx    <= '0;
      state      <= S_CLEAR;
    end else begin
      // output valid: set on load, dropped once taken
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == rhh_pkg::ADDR_W'(rhh_pkg::SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            mode      <= req.mode;
            cur_key   <= req.hkey;
            cur_val   <= req.value;
            dq        <= req.hkey;
            div_cnt   <= '0;
            idx       <= '0;
            res_value <= rhh_pkg::NO_VALUE;
            if ((req.hkey == rhh_pkg::EMPTY_KEY) || (req.mode == rhh_pkg::MODE_BAD)) begin
              res_status <= rhh_pkg::ST_INVALID;
              state      <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          idx     <= rem_step;
          dq      <= dq << 1;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 5'd31) begin
            home   <= rem_step;
            nprobe <= '0;
            state  <= S_FIND_RD;
          end
        end
        S_FIND_RD: begin
          state <= S_FIND_EV;
        end
        S_FIND_EV: begin
          priority if (rd.key == cur_key) begin
            if (mode == rhh_pkg::MODE_INSERT) begin
              res_status <= rhh_pkg::ST_DUPLICATE;
              state      <= S_DONE;
            end else begin
              res_value  <= rd.value;
              res_status <= rhh_pkg::ST_OK;
              if (mode == rhh_pkg::MODE_REMOVE) begin
                count  <= count - 1'b1;
                nprobe <= '0;
                state  <= S_REM_RD;
              end else begin
                state <= S_DONE;
              end
            end
          end else if (find_miss) begin
            if (mode != rhh_pkg::MODE_INSERT) begin
              res_status <= rhh_pkg::ST_NOT_FOUND;
              state      <= S_DONE;
            end else if (count > load_limit) begin
              res_status <= rhh_pkg::ST_FULL;
              state      <= S_DONE;
            end else begin
              idx      <= home;
              cur_dist <= '0;
              state    <= S_INS_RD;
            end
          end else begin
            idx    <= idx_nx;
            nprobe <= nprobe_inc;
            state  <= S_FIND_RD;
          end
        end
        S_INS_RD: begin
          state <= S_INS_EV;
        end
        S_INS_EV: begin
          if (rd.key == rhh_pkg::EMPTY_KEY) begin
            count      <= count + 1'b1;
            res_status <= rhh_pkg::ST_OK;
            state      <= S_DONE;
          end else begin
            // richer resident is displaced and carried on
            if (cur_dist > rd.probe_len) begin
              cur_key  <= rd.key;
              cur_val  <= rd.value;
              cur_dist <= rd.probe_len + 1'b1;
            end else begin
              cur_dist <= cur_dist + 1'b1;
            end
            idx   <= idx_nx;
            state <= S_INS_RD;
          end
        end
        S_REM_RD: begin
          state <= S_REM_EV;
        end
        S_REM_EV: begin
          if ((rd.key == rhh_pkg::EMPTY_KEY) || (rd.probe_len == '0)) begin
            state <= S_DONE;
          end else begin
            idx    <= idx_nx;
            nprobe <= nprobe_inc;
            state  <= (nprobe_inc >= capacity) ? S_REM_FIN : S_REM_RD;
          end
        end
        S_REM_FIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp   <= '{value_res: res_value, status: res_status, entry_count: count};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `RHH_ASSERT(a_count_le_cap, count <= capacity, "entry count above capacity")
  `RHH_ASSERT(a_probe_in_range,
    ((state != S_FIND_RD) && (state != S_INS_RD) && (state != S_REM_RD)) ||
    (idx < capacity), "probe slot outside capacity")
  `RHH_ASSERT_NEXT(a_count_step, !cfg_we,
    (count == $past(count)) || (count == $past(count) + 1'b1) ||
    (count == $past(count) - 1'b1), "entry count jumped")
  `RHH_ASSERT_NEXT(a_clear_empty, state == S_CLEAR, count == '0, "entries present during clear")

endmodule
